// ===== sv/cpt_pkg.sv =====
`default_nettype none
package cpt_pkg;

	// Bank geometry and field widths.
	localparam int NUM_TIMERS = 4;
	localparam int CNT_W = 16;
	localparam int CYC_W = 11;
	localparam int MASK_W = 4;

	// Command codes.
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_WR_CTL = 3'd1;
	localparam logic [2:0] CMD_WR_RLD = 3'd2;
	localparam logic [2:0] CMD_RD_CNT = 3'd3;
	localparam logic [2:0] CMD_RD_CTL = 3'd4;
	localparam logic [2:0] CMD_FORCE = 3'd5;

	// Control word bit positions.
	localparam int CTL_CASCADE = 2;
	localparam int CTL_IRQ = 6;
	localparam int CTL_ENABLE = 7;

	// Decoded command, already gated by the input handshake.
	typedef struct packed {
		logic tick;
		logic wr_ctl;
		logic wr_rld;
		logic frc_ovf;
	} cpt_cmd_t;

	// What each cell shows to the top level and to its upper neighbor.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] control;
		logic ovf;
		logic irq;
	} cpt_cell_stat_t;

	// One result item.
	typedef struct packed {
		logic [CNT_W-1:0] read_data;
		logic [MASK_W-1:0] overflow_mask;
		logic [MASK_W-1:0] irq_mask;
	} cpt_res_t;

	// Prescale period in cycles for a select code.
	function automatic logic [CYC_W-1:0] period(input logic [1:0] sel);
		logic [CYC_W-1:0] p;
		case (sel)
			2'd0: p = CYC_W'(1);
			2'd1: p = CYC_W'(64);
			2'd2: p = CYC_W'(256);
			default: p = CYC_W'(1024);
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cpt_cell.sv =====
`default_nettype none
module cpt_cell
	import cpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cpt_cmd_t cmd,
	input wire logic sel,
	input wire logic cascade_ok,
	input wire logic [CNT_W-1:0] write_data,
	input wire logic carry_in,
	output cpt_cell_stat_t stat
);

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] reload_q, reload_d;
	logic [CNT_W-1:0] control_q, control_d;
	logic [CYC_W-1:0] cycles_q, cycles_d;
	logic running, casc, free_run, inc, frc, ovf;

	// The control word keeps every written bit; the cascade bit only acts where allowed.
	assign running = control_q[CTL_ENABLE];
	assign casc = control_q[CTL_CASCADE] && cascade_ok;
	assign free_run = running && !casc;

	// Counting, overflow and register writes for this timer.
	always_comb begin
		inc = (cmd.tick && free_run && (cycles_q <= CYC_W'(1)))
			|| (carry_in && running && casc);
		frc = cmd.frc_ovf && sel && running;
		ovf = frc || (inc && (count_q == {CNT_W{1'b1}}));

		count_d = count_q;
		reload_d = reload_q;
		control_d = control_q;
		cycles_d = cycles_q;

		if (ovf) begin
			count_d = reload_q;
		end else if (inc) begin
			count_d = count_q + CNT_W'(1);
		end

		if (cmd.tick && free_run) begin
			if (cycles_q <= CYC_W'(1)) begin
				cycles_d = period(control_q[1:0]);
			end else begin
				cycles_d = cycles_q - CYC_W'(1);
			end
		end

		if (sel && cmd.wr_ctl) begin
			control_d = write_data;
			if (write_data[CTL_ENABLE] && !running) begin
				count_d = reload_q;
				cycles_d = period(write_data[1:0]);
			end else if (!write_data[CTL_ENABLE] && running) begin
				cycles_d = '0;
			end
		end

		if (sel && cmd.wr_rld) begin
			reload_d = write_data;
			if (!running) begin
				count_d = write_data;
			end
		end
	end

	// Timer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			reload_q <= '0;
			control_q <= '0;
			cycles_q <= '0;
		end else begin
			count_q <= count_d;
			reload_q <= reload_d;
			control_q <= control_d;
			cycles_q <= cycles_d;
		end
	end

	// Status toward the top level and the next cell.
	always_comb begin
		stat.count = count_q;
		stat.control = control_q;
		stat.ovf = ovf;
		stat.irq = ovf && control_q[CTL_IRQ];
	end

`ifndef ASSERT_OFF
	a_ovf_running: assert property (@(posedge clk) disable iff (!arst_n)
		ovf |-> running)
		else $error("stopped timer overflowed");
	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(sel && cmd.wr_ctl && !write_data[CTL_ENABLE]) |=> (cycles_q == '0))
		else $error("stopping a timer left its prescale count");
`endif

endmodule
`default_nettype wire

// ===== sv/cpt_outbuf.sv =====
`default_nettype none
module cpt_outbuf
	import cpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire cpt_res_t in_res,
	output logic out_valid,
	input wire logic out_stall,
	output cpt_res_t out_res
);

	logic out_valid_q, skid_valid_q;
	cpt_res_t out_q, skid_q;
	logic acc, out_free;

	assign in_stall = skid_valid_q;
	assign acc = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res = out_q;

	// Control: output register backed by one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_valid_q || acc;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= in_res;
			end
		end else if (acc) begin
			skid_q <= in_res;
		end
	end

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while output register empty");
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && out_valid_q && out_stall) |=> (skid_valid_q && out_valid_q))
		else $error("item taken under stall was not held");
`endif

endmodule
`default_nettype wire

// ===== sv/cascaded_prescaled_timer_bank.sv =====
`default_nettype none
// Bank of cascadable 16-bit timers, one cell per timer, overflow carried cell to cell.
// Latency: the result of an item is registered before it appears at the outputs.
// Throughput: one item per cycle; the output register and one skid entry hold results
// while the output is stalled, so input stalls only when both are full.
// Reset: arst_n clears all counters, reload values, control words and prescalers at once.
module cascaded_prescaled_timer_bank
	import cpt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] command,
	input wire logic [1:0] timer_index,
	input wire logic [15:0] write_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [15:0] read_data,
	output logic [3:0] overflow_mask,
	output logic [3:0] irq_mask
);

	logic accept;
	cpt_cmd_t cmd;
	cpt_cell_stat_t stat [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] sel;
	logic [CNT_W-1:0] rd_data;
	logic [MASK_W-1:0] ovf_vec, irq_vec;
	cpt_res_t res, res_out;

	assign accept = in_valid && !in_stall;

	// Command decode, gated by the input handshake.
	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (command)
				CMD_TICK: cmd.tick = 1'b1;
				CMD_WR_CTL: cmd.wr_ctl = 1'b1;
				CMD_WR_RLD: cmd.wr_rld = 1'b1;
				CMD_FORCE: cmd.frc_ovf = 1'b1;
				default: cmd = '0;
			endcase
		end
	end

	// Row of timer cells; each overflow below the top cell feeds the cell above.
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		assign sel[i] = (int'(timer_index) == i);
		if (i == 0) begin : g_first
			cpt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.sel(sel[i]),
				.cascade_ok(1'b0),
				.write_data(write_data),
				.carry_in(1'b0),
				.stat(stat[i])
			);
		end else begin : g_next
			cpt_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.sel(sel[i]),
				.cascade_ok(1'b1),
				.write_data(write_data),
				.carry_in(stat[i-1].ovf),
				.stat(stat[i])
			);
		end
	end

	// Read data selection.
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (sel[i]) begin
				if (command == CMD_RD_CNT) begin
					rd_data = stat[i].count;
				end else if (command == CMD_RD_CTL) begin
					rd_data = stat[i].control;
				end
			end
		end
	end

	// Overflow and interrupt masks for the low timers.
	for (genvar m = 0; m < MASK_W; m++) begin : g_mask
		if (m < NUM_TIMERS) begin : g_live
			assign ovf_vec[m] = stat[m].ovf;
			assign irq_vec[m] = stat[m].irq;
		end else begin : g_none
			assign ovf_vec[m] = 1'b0;
			assign irq_vec[m] = 1'b0;
		end
	end

	assign res = {rd_data, ovf_vec, irq_vec};

	cpt_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_res(res),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(res_out)
	);

	assign read_data = res_out.read_data;
	assign overflow_mask = res_out.overflow_mask;
	assign irq_mask = res_out.irq_mask;

`ifndef ASSERT_OFF
	a_irq_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((irq_mask & ~overflow_mask) == 4'd0))
		else $error("interrupt without overflow");
	a_read_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command != CMD_RD_CNT && command != CMD_RD_CTL)
		|-> (res.read_data == '0))
		else $error("read data on a non-read item");
`endif

endmodule
`default_nettype wire
